// File: rtl/fts_pkg.sv
// Package for the fixed-timestep RK4 spring block.
// Types, register indexes, reset values and sequencer states shared by the front, queue, back and top files.
package fts_pkg;

  localparam int FTS_MAX_STEPS  = 16;
  localparam int FTS_DATA_WIDTH = 32;

  localparam logic [15:0] RST_STIFFNESS = 16'd2560;
  localparam logic [15:0] RST_DAMPING   = 16'd256;
  localparam logic [15:0] RST_STEP_SIZE = 16'd6554;
  localparam logic [17:0] RST_MAX_FRAME = 18'd16384;
  localparam logic [31:0] RST_START_POS = 32'd6553600;
  localparam logic [31:0] RST_START_VEL = 32'd0;

  typedef enum logic [2:0] {
    REG_STIFFNESS = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_STEP_SIZE = 3'd2,
    REG_MAX_FRAME = 3'd3,
    REG_START_POS = 3'd4,
    REG_START_VEL = 3'd5
  } fts_reg_t;

  // frame delta after clamping, handed from front to back
  typedef struct packed {
    logic [17:0] delta;
    logic        clamped;
  } fts_item_t;

  typedef struct packed {
    logic [15:0] stiffness;
    logic [15:0] damping;
    logic [15:0] step_size;
  } fts_cfg_t;

  // start register writes reload the spring state
  typedef struct packed {
    logic        pos_we;
    logic        vel_we;
    logic [31:0] value;
  } fts_load_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK,
    S_KX, S_BV, S_ACC,
    S_OX, S_OV, S_OV2,
    S_DIVX, S_DIVV,
    S_UPX, S_UPV, S_UPV2,
    S_ALPHA,
    S_BL0, S_BL1, S_BL2, S_BL3, S_BL4,
    S_OUT
  } fts_state_t;

endpackage

// File: rtl/fts_if.sv
// Handshake channels of the spring block: frame times in, shown state out.
// Depends on nothing.
interface fts_frame_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_time;
  modport source (output valid, output frame_time, input ready);
  modport sink (input valid, input frame_time, output ready);
endinterface

interface fts_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] shown_position;
  logic signed [31:0] shown_velocity;
  logic        [4:0]  steps_taken;
  logic               frame_clamped;
  modport source (output valid, output shown_position, output shown_velocity,
                  output steps_taken, output frame_clamped, input ready);
  modport sink (input valid, input shown_position, input shown_velocity,
                input steps_taken, input frame_clamped, output ready);
endinterface

// File: rtl/fts_front.sv
// Front end: takes frame words, forms the clamped delta since the last frame.
// Depends on fts_pkg and fts_frame_if.
module fts_front (
  input  logic                  clk,
  input  logic                  rst,
  fts_frame_if.sink             frame,
  input  logic [17:0]           max_frame,
  output logic                  push_valid,
  input  logic                  push_ready,
  output fts_pkg::fts_item_t    push_item
);

  logic [31:0] last_time;
  logic [31:0] delta;
  logic        over;

  assign delta       = frame.frame_time - last_time;
  assign over        = delta > {14'd0, max_frame};
  assign frame.ready = push_ready;
  assign push_valid  = frame.valid;

  always_comb begin
    push_item.clamped = over;
    push_item.delta   = over ? max_frame : delta[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (frame.valid && push_ready) begin
      last_time <= frame.frame_time;
    end
  end

endmodule

// File: rtl/fts_queue.sv
// Two-word queue between front and back.
// Depends on fts_pkg.
module fts_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fts_pkg::fts_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fts_pkg::fts_item_t out_item
);

  fts_pkg::fts_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/fts_back.sv
// Back end: accumulator, RK4 sequencer on one shared multiplier, divide-by-6
// and alpha dividers, blend, output register. Depends on fts_pkg, fts_result_if.
module fts_back #(
  parameter int MAX_STEPS  = fts_pkg::FTS_MAX_STEPS,
  parameter int DATA_WIDTH = fts_pkg::FTS_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  fts_pkg::fts_item_t q_item,
  input  fts_pkg::fts_cfg_t  cfg,
  input  fts_pkg::fts_load_t load,
  fts_result_if.source       res
);

  localparam int W   = DATA_WIDTH;
  localparam int PW  = W + 18;
  localparam int NB  = (W + 1 + 7) / 8;
  localparam int DBW = NB * 8;
  localparam int STW = $clog2(MAX_STEPS + 1);

  function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
    if (v[PW-1:W-1] == {(PW-W+1){v[PW-1]}}) sat = v[W-1:0];
    else sat = v[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v[PW-1:31] == {(PW-31){v[PW-1]}}) sat32 = v[31:0];
    else sat32 = v[PW-1] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [PW-1:0] ext(input logic signed [W-1:0] v);
    ext = {{(PW-W){v[W-1]}}, v};
  endfunction

  fts_pkg::fts_state_t state, state_next;

  logic        [31:0]   acc;
  logic        [STW-1:0] steps;
  logic                 clamped;
  logic signed [W-1:0]  x, v, px, pv, xs, vs, kx, dx_r, dv_r, sx_r, sv_r;
  logic signed [PW-1:0] sum_x, sum_v, bsum;
  logic        [1:0]    stage;
  logic        [4:0]    cnt;

  // shared multiplier
  logic signed [W-1:0]  mul_a;
  logic        [16:0]   mul_b;
  logic signed [PW-1:0] prod;

  // divide-by-6 unit
  logic                 div_neg;
  logic [DBW-1:0]       dsh, dq, dq_next;
  logic [1:0]           drem, drem_next;
  logic [9:0]           dt_word;
  logic [20:0]          dmul;
  logic [7:0]           dqd;
  logic signed [PW-1:0] div_q;
  logic signed [W-1:0]  div_res;

  // alpha divider
  logic [16:0] ar;
  logic [15:0] aq;
  logic [17:0] ar2;
  logic        abit;
  logic [16:0] alpha;

  logic        [15:0]   step;
  logic                 step_ok;
  logic        [32:0]   acc_add;
  logic signed [W-1:0]  bv_c, a_c, xs_c, vs_c, xn_c, vn_c;
  logic signed [PW-1:0] sum_x_next, sum_v_next;
  logic signed [31:0]   bl_c;
  logic signed [31:0]   bl_pos, bl_vel;
  logic                 out_valid;
  logic signed [31:0]   out_pos, out_vel;
  logic [4:0]           out_steps;
  logic                 out_clamped;
  logic                 out_take;

  assign step    = (cfg.step_size == 16'd0) ? 16'd1 : cfg.step_size;
  assign step_ok = acc >= {16'd0, step};
  assign acc_add = {1'b0, acc} + {15'd0, q_item.delta};
  assign q_ready = (state == fts_pkg::S_IDLE);
  assign out_take = !out_valid || res.ready;

  assign bv_c = sat(prod >>> 8);
  assign a_c  = sat(-ext(kx) - ext(bv_c));
  assign xs_c = sat(ext(x) + (prod >>> ((stage == 2'd3) ? 16 : 17)));
  assign vs_c = sat(ext(v) + (prod >>> ((stage == 2'd3) ? 16 : 17)));
  assign xn_c = sat(ext(x) + (prod >>> 16));
  assign vn_c = sat(ext(v) + (prod >>> 16));
  assign bl_c = sat32((bsum + prod) >>> 16);

  // RK4 weights: 1, 2, 2, 1
  always_comb begin
    case (stage)
      2'd0: begin
        sum_x_next = ext(vs);
        sum_v_next = ext(a_c);
      end
      2'd3: begin
        sum_x_next = sum_x + ext(vs);
        sum_v_next = sum_v + ext(a_c);
      end
      default: begin
        sum_x_next = sum_x + (ext(vs) <<< 1);
        sum_v_next = sum_v + (ext(a_c) <<< 1);
      end
    endcase
  end

  // one byte of quotient per cycle; x*683>>11 is exact /3 below 768
  assign dt_word   = {drem, dsh[DBW-1 -: 8]};
  assign dmul      = 21'(dt_word) * 21'd683;
  assign dqd       = dmul[18:11];
  assign drem_next = 2'(dt_word - 10'(dqd) * 10'd3);
  assign dq_next   = {dq[DBW-9:0], dqd};
  assign div_q     = PW'(dq_next);
  assign div_res   = sat(div_neg ? ~div_q : div_q);

  assign ar2  = {ar, 1'b0};
  assign abit = ar2 >= {2'b00, step};

  always_comb begin
    mul_a = x;
    mul_b = 17'd0;
    case (state)
      fts_pkg::S_KX:  begin mul_a = xs;   mul_b = {1'b0, cfg.stiffness}; end
      fts_pkg::S_BV:  begin mul_a = vs;   mul_b = {1'b0, cfg.damping}; end
      fts_pkg::S_OX:  begin mul_a = dx_r; mul_b = {1'b0, step}; end
      fts_pkg::S_OV:  begin mul_a = dv_r; mul_b = {1'b0, step}; end
      fts_pkg::S_UPX: begin mul_a = sx_r; mul_b = {1'b0, step}; end
      fts_pkg::S_UPV: begin mul_a = sv_r; mul_b = {1'b0, step}; end
      fts_pkg::S_BL0: begin mul_a = x;    mul_b = alpha; end
      fts_pkg::S_BL1: begin mul_a = px;   mul_b = 17'h10000 - alpha; end
      fts_pkg::S_BL2: begin mul_a = v;    mul_b = alpha; end
      fts_pkg::S_BL3: begin mul_a = pv;   mul_b = 17'h10000 - alpha; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, mul_b});
  end

  always_comb begin
    state_next = state;
    case (state)
      fts_pkg::S_IDLE:  if (q_valid) state_next = fts_pkg::S_CHECK;
      fts_pkg::S_CHECK: begin
        if (step_ok && steps < STW'(MAX_STEPS)) state_next = fts_pkg::S_KX;
        else if (step_ok) state_next = fts_pkg::S_BL0;
        else state_next = fts_pkg::S_ALPHA;
      end
      fts_pkg::S_KX:  state_next = fts_pkg::S_BV;
      fts_pkg::S_BV:  state_next = fts_pkg::S_ACC;
      fts_pkg::S_ACC: state_next = (stage == 2'd3) ? fts_pkg::S_DIVX : fts_pkg::S_OX;
      fts_pkg::S_OX:  state_next = fts_pkg::S_OV;
      fts_pkg::S_OV:  state_next = fts_pkg::S_OV2;
      fts_pkg::S_OV2: state_next = fts_pkg::S_KX;
      fts_pkg::S_DIVX: if (cnt == 5'(NB - 1)) state_next = fts_pkg::S_DIVV;
      fts_pkg::S_DIVV: if (cnt == 5'(NB - 1)) state_next = fts_pkg::S_UPX;
      fts_pkg::S_UPX:  state_next = fts_pkg::S_UPV;
      fts_pkg::S_UPV:  state_next = fts_pkg::S_UPV2;
      fts_pkg::S_UPV2: state_next = fts_pkg::S_CHECK;
      fts_pkg::S_ALPHA: if (cnt == 5'd15) state_next = fts_pkg::S_BL0;
      fts_pkg::S_BL0: state_next = alpha[16] ? fts_pkg::S_OUT : fts_pkg::S_BL1;
      fts_pkg::S_BL1: state_next = fts_pkg::S_BL2;
      fts_pkg::S_BL2: state_next = fts_pkg::S_BL3;
      fts_pkg::S_BL3: state_next = fts_pkg::S_BL4;
      fts_pkg::S_BL4: state_next = fts_pkg::S_OUT;
      fts_pkg::S_OUT: if (out_take) state_next = fts_pkg::S_IDLE;
      default: state_next = fts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      steps     <= '0;
      x         <= sat(PW'($signed(fts_pkg::RST_START_POS)));
      px        <= sat(PW'($signed(fts_pkg::RST_START_POS)));
      v         <= sat(PW'($signed(fts_pkg::RST_START_VEL)));
      pv        <= sat(PW'($signed(fts_pkg::RST_START_VEL)));
      out_valid <= 1'b0;
    end else begin
      if (load.pos_we) begin
        x  <= sat(PW'($signed(load.value)));
        px <= sat(PW'($signed(load.value)));
      end
      if (load.vel_we) begin
        v  <= sat(PW'($signed(load.value)));
        pv <= sat(PW'($signed(load.value)));
      end
      if (res.valid && res.ready && state != fts_pkg::S_OUT) out_valid <= 1'b0;
      case (state)
        fts_pkg::S_IDLE: if (q_valid) begin
          acc     <= acc_add[32] ? 32'hFFFF_FFFF : acc_add[31:0];
          clamped <= q_item.clamped;
          steps   <= '0;
        end
        fts_pkg::S_CHECK: begin
          if (step_ok && steps < STW'(MAX_STEPS)) begin
            acc   <= acc - {16'd0, step};
            px    <= x;
            pv    <= v;
            xs    <= x;
            vs    <= v;
            stage <= 2'd0;
          end else if (step_ok) begin
            alpha <= 17'h10000;
          end else begin
            ar  <= {1'b0, acc[15:0]};
            aq  <= '0;
            cnt <= '0;
          end
        end
        fts_pkg::S_BV:  kx <= sat(prod >>> 8);
        fts_pkg::S_ACC: begin
          sum_x <= sum_x_next;
          sum_v <= sum_v_next;
          dx_r  <= vs;
          dv_r  <= a_c;
          stage <= stage + 2'd1;
          if (stage == 2'd3) begin
            div_neg <= sum_x_next[PW-1];
            dsh     <= DBW'(sum_x_next[PW-1] ? (~sum_x_next) >> 1 : sum_x_next >> 1);
            drem    <= '0;
            dq      <= '0;
            cnt     <= '0;
          end
        end
        fts_pkg::S_OV:  xs <= xs_c;
        fts_pkg::S_OV2: vs <= vs_c;
        fts_pkg::S_DIVX, fts_pkg::S_DIVV: begin
          if (cnt == 5'(NB - 1)) begin
            cnt  <= '0;
            drem <= '0;
            dq   <= '0;
            if (state == fts_pkg::S_DIVX) begin
              sx_r    <= div_res;
              div_neg <= sum_v[PW-1];
              dsh     <= DBW'(sum_v[PW-1] ? (~sum_v) >> 1 : sum_v >> 1);
            end else begin
              sv_r <= div_res;
            end
          end else begin
            dsh  <= dsh << 8;
            drem <= drem_next;
            dq   <= dq_next;
            cnt  <= cnt + 5'd1;
          end
        end
        fts_pkg::S_UPV:  x <= xn_c;
        fts_pkg::S_UPV2: begin
          v     <= vn_c;
          steps <= steps + STW'(1);
        end
        fts_pkg::S_ALPHA: begin
          ar  <= abit ? 17'(ar2 - {2'b00, step}) : ar2[16:0];
          aq  <= {aq[14:0], abit};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) alpha <= {1'b0, aq[14:0], abit};
        end
        fts_pkg::S_BL0: if (alpha[16]) begin
          bl_pos <= sat32(ext(x));
          bl_vel <= sat32(ext(v));
        end
        fts_pkg::S_BL1: bsum <= prod;
        fts_pkg::S_BL2: bl_pos <= bl_c;
        fts_pkg::S_BL3: bsum <= prod;
        fts_pkg::S_BL4: bl_vel <= bl_c;
        // the held result word stays put until it is taken
        fts_pkg::S_OUT: if (out_take) begin
          out_valid   <= 1'b1;
          out_pos     <= bl_pos;
          out_vel     <= bl_vel;
          out_steps   <= 5'(steps);
          out_clamped <= clamped;
        end
        default: begin end
      endcase
    end
  end

  assign res.valid          = out_valid;
  assign res.shown_position = out_pos;
  assign res.shown_velocity = out_vel;
  assign res.steps_taken    = out_steps;
  assign res.frame_clamped  = out_clamped;

`ifndef NO_ASSERTIONS
  a_step_cap: assert property (@(posedge clk) disable iff (rst)
    steps <= STW'(MAX_STEPS)) else $error("step count above cap");
  a_alpha_frac: assert property (@(posedge clk) disable iff (rst)
    state == fts_pkg::S_ALPHA |-> acc < {16'd0, step}) else $error("alpha with full step left");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == fts_pkg::S_OUT && out_take) |=> res.valid) else $error("result not loaded");
  a_take_item: assert property (@(posedge clk) disable iff (rst)
    (state == fts_pkg::S_IDLE && q_valid) |=> state == fts_pkg::S_CHECK)
    else $error("queued word not taken");
`endif

endmodule

// File: rtl/fixed_timestep_rk4_spring.sv
// Fixed-timestep damped spring (a = -k*x - b*v) with RK4 steps and blended output.
// Each frame word goes from the frame port into the queue, then through the RK4
// sequencer to the result register, and may wait until the result register can take it;
// the alpha divide and blend are skipped when the step cap leaves a full step.
// The RK4 sequencer runs every product through one shared multiplier and
// divides by six one byte per cycle. A two-word queue lets frames be taken
// while a step is running and a result register holds the last answer.
module fixed_timestep_rk4_spring #(
  parameter int MAX_STEPS  = fts_pkg::FTS_MAX_STEPS,
  parameter int DATA_WIDTH = fts_pkg::FTS_DATA_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  fts_frame_if.sink    frame,
  fts_result_if.source result,
  input  logic         wr_en,
  input  logic [2:0]   wr_index,
  input  logic [31:0]  wr_data
);

  logic [15:0] stiffness, damping, step_size;
  logic [17:0] max_frame;
  logic        push_valid, push_ready, q_valid, q_ready;
  fts_pkg::fts_item_t push_item, q_item;
  fts_pkg::fts_cfg_t  cfg;
  fts_pkg::fts_load_t load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= fts_pkg::RST_STIFFNESS;
      damping   <= fts_pkg::RST_DAMPING;
      step_size <= fts_pkg::RST_STEP_SIZE;
      max_frame <= fts_pkg::RST_MAX_FRAME;
    end else if (wr_en) begin
      case (wr_index)
        fts_pkg::REG_STIFFNESS: stiffness <= wr_data[15:0];
        fts_pkg::REG_DAMPING:   damping   <= wr_data[15:0];
        fts_pkg::REG_STEP_SIZE: step_size <= wr_data[15:0];
        fts_pkg::REG_MAX_FRAME: max_frame <= wr_data[17:0];
        default: begin end
      endcase
    end
  end

  always_comb begin
    cfg.stiffness = stiffness;
    cfg.damping   = damping;
    cfg.step_size = step_size;
    load.pos_we   = wr_en && (wr_index == fts_pkg::REG_START_POS);
    load.vel_we   = wr_en && (wr_index == fts_pkg::REG_START_VEL);
    load.value    = wr_data;
  end

  fts_front u_front (
    .clk, .rst, .frame, .max_frame,
    .push_valid, .push_ready, .push_item
  );

  fts_queue u_queue (
    .clk, .rst,
    .in_valid(push_valid), .in_ready(push_ready), .in_item(push_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  fts_back #(.MAX_STEPS(MAX_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .cfg, .load, .res(result)
  );

endmodule
